@@ rtl/core/ptd_pkg.sv @@
// shared types, constants and reset tables for the periodic task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

   localparam int TASK_COUNT_DEF = 6;
   localparam int TIME_WIDTH_DEF = 32;
   localparam int TASK_IDX_W     = 4;
   localparam int PERIOD_W       = 32;
   localparam int KIND_W         = 2;

   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(1000);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 2'd0,
      KIND_ENABLE     = 2'd1,
      KIND_DISABLE    = 2'd2,
      KIND_SET_PERIOD = 2'd3
   } kind_type;

   // table access requests from the sequencer
   typedef struct packed {
      logic                  rd_en;
      logic [TASK_IDX_W-1:0] rd_addr;
      logic                  lr_we;
      logic                  per_we;
      logic                  en_set;
      logic                  en_clr;
      logic [TASK_IDX_W-1:0] wr_addr;
   } tbl_ctl_type;

   function automatic logic [PERIOD_W-1:0] reset_period(input logic [TASK_IDX_W-1:0] idx);
      logic [PERIOD_W-1:0] p;
      case (idx)
         4'd0:    p = PERIOD_W'(50);
         4'd1:    p = PERIOD_W'(10);
         4'd2:    p = PERIOD_W'(10);
         4'd3:    p = PERIOD_W'(1);
         4'd4:    p = PERIOD_W'(20);
         4'd5:    p = PERIOD_W'(25);
         default: p = DEFAULT_PERIOD;
      endcase
      return p;
   endfunction

   function automatic logic reset_enable(input logic [TASK_IDX_W-1:0] idx);
      logic e;
      case (idx)
         4'd0:    e = 1'b1;
         4'd1:    e = 1'b1;
         default: e = 1'b0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ptd_table.sv @@
// task table: period and last-run memories, enable flags
`timescale 1ns / 1ps
`default_nettype none

module ptd_table #(
   parameter int TASK_COUNT = ptd_pkg::TASK_COUNT_DEF,
   parameter int TIME_WIDTH = ptd_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptd_pkg::tbl_ctl_type          ctl,
   input  wire logic [TIME_WIDTH-1:0]         wr_time,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]  wr_period,
   output logic                               rd_enabled,
   output logic [ptd_pkg::PERIOD_W-1:0]       rd_period,
   output logic [TIME_WIDTH-1:0]              rd_last_run
);
   import ptd_pkg::*;

   localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

   logic [PERIOD_W-1:0]   per_mem [TASK_COUNT];
   logic [TIME_WIDTH-1:0] lr_mem  [TASK_COUNT];

   logic [TASK_COUNT-1:0] per_vld_ff;
   logic [TASK_COUNT-1:0] lr_vld_ff;
   logic [TASK_COUNT-1:0] en_ff;

   logic [PERIOD_W-1:0]   per_rd_ff;
   logic [TIME_WIDTH-1:0] lr_rd_ff;
   logic                  per_vld_rd_ff;
   logic                  lr_vld_rd_ff;
   logic                  en_rd_ff;
   logic [TASK_IDX_W-1:0] rd_idx_ff;

   logic [AW-1:0] wa;
   logic [AW-1:0] ra;

   assign wa = ctl.wr_addr[AW-1:0];
   assign ra = ctl.rd_addr[AW-1:0];

   // flags: entries not yet written read back their power-on values
   always_ff @(posedge clock) begin
      if (reset) begin
         per_vld_ff <= '0;
         lr_vld_ff  <= '0;
         for (int i = 0; i < TASK_COUNT; i++) begin
            en_ff[i] <= reset_enable(TASK_IDX_W'(i));
         end
      end else begin
         if (ctl.per_we) per_vld_ff[wa] <= 1'b1;
         if (ctl.lr_we)  lr_vld_ff[wa]  <= 1'b1;
         if (ctl.en_set) en_ff[wa]      <= 1'b1;
         if (ctl.en_clr) en_ff[wa]      <= 1'b0;
      end
   end

   // memories with registered read port
   always_ff @(posedge clock) begin
      if (ctl.per_we) per_mem[wa] <= wr_period;
      if (ctl.lr_we)  lr_mem[wa]  <= wr_time;
      if (ctl.rd_en) begin
         per_rd_ff     <= per_mem[ra];
         lr_rd_ff      <= lr_mem[ra];
         per_vld_rd_ff <= per_vld_ff[ra];
         lr_vld_rd_ff  <= lr_vld_ff[ra];
         en_rd_ff      <= en_ff[ra];
         rd_idx_ff     <= ctl.rd_addr;
      end
   end

   assign rd_enabled  = en_rd_ff;
   assign rd_period   = per_vld_rd_ff ? per_rd_ff : reset_period(rd_idx_ff);
   assign rd_last_run = lr_vld_rd_ff ? lr_rd_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/ptd_ctrl.sv @@
// request decode, table walk sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module ptd_ctrl #(
   parameter int TASK_COUNT = ptd_pkg::TASK_COUNT_DEF,
   parameter int TIME_WIDTH = ptd_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ptd_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [ptd_pkg::TASK_IDX_W-1:0]  req_task_index,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]    req_new_period,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ptd_pkg::TASK_IDX_W-1:0]       rsp_due_task,
   output logic                                 rsp_last_due,
   output ptd_pkg::tbl_ctl_type                 ctl,
   output logic [TIME_WIDTH-1:0]                wr_time,
   output logic [ptd_pkg::PERIOD_W-1:0]         wr_period,
   input  wire logic                            rd_enabled,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]    rd_period,
   input  wire logic [TIME_WIDTH-1:0]           rd_last_run
);
   import ptd_pkg::*;

   localparam int AW    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int CMP_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         ev_idx_ff, ev_idx_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TASK_IDX_W-1:0] rsp_task_ff, rsp_task_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_accept;
   logic                  in_range;
   logic                  out_free;
   logic [TIME_WIDTH-1:0] diff;
   logic                  hit;
   logic                  advance;
   logic                  ev_last;
   logic                  rsp_load;
   logic [AW-1:0]         ev_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = ({1'b0, req_task_index} < (TASK_IDX_W + 1)'(TASK_COUNT));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign diff    = now_ff - rd_last_run;
   assign hit     = rd_enabled && (CMP_W'(diff) >= CMP_W'(rd_period));
   // a hit with a pending index needs the result register free
   assign advance = !hit || !pend_valid_ff || out_free;
   assign ev_last = (ev_idx_ff == AW'(TASK_COUNT - 1));
   assign ev_next = ev_idx_ff + AW'(1);

   always_comb begin
      state_in      = state_ff;
      ev_idx_in     = ev_idx_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_load      = 1'b0;
      rsp_task_in   = rsp_task_ff;
      rsp_last_in   = rsp_last_ff;
      ctl           = '0;
      wr_time       = now_ff;
      wr_period     = (req_new_period == '0) ? PERIOD_W'(1) : req_new_period;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (kind_type'(req_kind))
                  KIND_TICK: begin
                     state_in    = ST_WALK;
                     ev_idx_in   = '0;
                     now_in      = TIME_WIDTH'(req_now_ms);
                     ctl.rd_en   = 1'b1;
                     ctl.rd_addr = '0;
                  end
                  KIND_ENABLE: begin
                     ctl.en_set  = in_range;
                     ctl.wr_addr = req_task_index;
                  end
                  KIND_DISABLE: begin
                     ctl.en_clr  = in_range;
                     ctl.wr_addr = req_task_index;
                  end
                  KIND_SET_PERIOD: begin
                     ctl.per_we  = in_range;
                     ctl.wr_addr = req_task_index;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (advance) begin
               if (hit) begin
                  ctl.lr_we     = 1'b1;
                  ctl.wr_addr   = TASK_IDX_W'(ev_idx_ff);
                  pend_valid_in = 1'b1;
                  pend_idx_in   = ev_idx_ff;
                  // an earlier due task is known not to be the last one
                  if (pend_valid_ff) begin
                     rsp_load    = 1'b1;
                     rsp_task_in = TASK_IDX_W'(pend_idx_ff);
                     rsp_last_in = 1'b0;
                  end
               end
               if (ev_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  ev_idx_in   = ev_next;
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = TASK_IDX_W'(ev_next);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_task_in   = TASK_IDX_W'(pend_idx_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff   <= ev_idx_in;
      now_ff      <= now_in;
      pend_idx_ff <= pend_idx_in;
      if (rsp_load) begin
         rsp_task_ff <= rsp_task_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_due_task = rsp_task_ff;
   assign rsp_last_due = rsp_last_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending due task left over in idle");

   a_lr_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ctl.lr_we |-> (state_ff == ST_WALK))
      else $error("last-run write outside table walk");

   a_cfg_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (ctl.per_we || ctl.en_set || ctl.en_clr) |-> (state_ff == ST_IDLE) && req_accept)
      else $error("table update without accepted transaction");

   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) && pend_valid_ff && out_free)
         |=> ((state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("final due task not delivered as last");

endmodule

`default_nettype wire

@@ rtl/core/periodic_task_dispatcher.sv @@
// top level of the periodic task dispatcher
// tick transaction: accepted in idle, then the walk reads one table entry per cycle while the
//   result side does not stall, set by the single read port of the task table, then a flush
//   state hands out the final due task
// enable, disable and set-period transactions: written on acceptance, no result
// the final due task is loaded into the result register in the flush state
// reset: synchronous; enable flags load their defaults and the memories' written flags
//   clear, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher #(
   parameter int TASK_COUNT = ptd_pkg::TASK_COUNT_DEF,
   parameter int TIME_WIDTH = ptd_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ptd_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [ptd_pkg::TASK_IDX_W-1:0]  req_task_index,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic [ptd_pkg::PERIOD_W-1:0]    req_new_period,
   // response channel, one transaction per due task
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ptd_pkg::TASK_IDX_W-1:0]       rsp_due_task,
   output logic                                 rsp_last_due
);
   import ptd_pkg::*;

   // table access from the sequencer
   tbl_ctl_type           ctl;
   logic [TIME_WIDTH-1:0] wr_time;
   logic [PERIOD_W-1:0]   wr_period;

   // registered read data, valid in the cycle after the read request
   logic                  rd_enabled;
   logic [PERIOD_W-1:0]   rd_period;
   logic [TIME_WIDTH-1:0] rd_last_run;

   // sequencer: decodes requests, walks the table, holds one due task back
   // until it knows whether a later one follows
   ptd_ctrl #(
      .TASK_COUNT (TASK_COUNT),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_task_index (req_task_index),
      .req_now_ms     (req_now_ms),
      .req_new_period (req_new_period),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_due_task   (rsp_due_task),
      .rsp_last_due   (rsp_last_due),
      .ctl            (ctl),
      .wr_time        (wr_time),
      .wr_period      (wr_period),
      .rd_enabled     (rd_enabled),
      .rd_period      (rd_period),
      .rd_last_run    (rd_last_run)
   );

   // task table: periods and last-run times in memories, enables in flops
   ptd_table #(
      .TASK_COUNT (TASK_COUNT),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .wr_time     (wr_time),
      .wr_period   (wr_period),
      .rd_enabled  (rd_enabled),
      .rd_period   (rd_period),
      .rd_last_run (rd_last_run)
   );

endmodule

`default_nettype wire

@@ bench/periodic_task_dispatcher_test.sv @@
// self-checking testbench for the periodic task dispatcher
`timescale 1ns / 1ps

module periodic_task_dispatcher_test;
   import ptd_pkg::*;

   localparam int TASKS = TASK_COUNT_DEF;
   localparam int STALL_LIMIT = 3000;   // cycles with no transaction on either side
   localparam int LONG_HOLD = 300;      // one long receiver hold-off to back up the block
   localparam int HOLD_AT_RESULT = 80;
   localparam int RANDOM_ITEMS = 208;

   // one request transaction plus a flag that makes the sender drain first
   typedef struct {
      kind_type              kind;
      logic [TASK_IDX_W-1:0] task_index;
      logic [31:0]           now_ms;
      logic [PERIOD_W-1:0]   new_period;
      bit                    hold_for_drain;
   } request_type;

   // one expected response transaction
   typedef struct {
      logic [TASK_IDX_W-1:0] due_task;
      logic                  last_due;
   } due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = KIND_TICK;
   logic [TASK_IDX_W-1:0] req_task_index = '0;
   logic [31:0]           req_now_ms = '0;
   logic [PERIOD_W-1:0]   req_new_period = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [TASK_IDX_W-1:0] rsp_due_task;
   logic                  rsp_last_due;

   // scheduler table as the predictor sees it
   logic                sched_enabled [TASKS];
   logic [PERIOD_W-1:0] sched_period [TASKS];
   logic [31:0]         sched_last_run [TASKS];

   request_type request_queue [$];
   due_type     pending_due [$];
   request_type offered_req = '{KIND_TICK, '0, '0, '0, 1'b0};

   int  send_gap = 0;
   bit  sender_calm = 1'b0;
   int  rsp_wait = 0;
   int  long_hold = 0;
   bit  receiver_calm = 1'b1;
   int  results_seen = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;

   periodic_task_dispatcher dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_task_index (req_task_index),
      .req_now_ms     (req_now_ms),
      .req_new_period (req_new_period),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_due_task   (rsp_due_task),
      .rsp_last_due   (rsp_last_due)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // table update for control transactions, due scan for ticks
   function automatic void apply_request(input request_type r);
      due_type     hits [$];
      logic [31:0] age;
      if (r.kind != KIND_TICK) begin
         // indexes past the table are dropped silently
         if (int'(r.task_index) < TASKS) begin
            case (r.kind)
               KIND_ENABLE:     sched_enabled[r.task_index] = 1'b1;
               KIND_DISABLE:    sched_enabled[r.task_index] = 1'b0;
               KIND_SET_PERIOD: sched_period[r.task_index] =
                                   (r.new_period == '0) ? PERIOD_W'(1) : r.new_period;
               default: ;
            endcase
         end
      end else begin
         // one now value for the whole pass, age wraps modulo 2^32
         for (int i = 0; i < TASKS; i++) begin
            age = r.now_ms - sched_last_run[i];
            if (sched_enabled[i] && age >= sched_period[i]) begin
               sched_last_run[i] = r.now_ms;
               hits.push_back('{due_task: TASK_IDX_W'(i), last_due: 1'b0});
            end
         end
         if (hits.size() != 0) hits[hits.size() - 1].last_due = 1'b1;
         foreach (hits[k]) pending_due.push_back(hits[k]);
      end
   endfunction

   task automatic add_item(input kind_type kind, input int idx, input logic [31:0] now,
                           input logic [31:0] per, input bit drain);
      request_queue.push_back('{kind, TASK_IDX_W'(idx), now, per, drain});
   endtask

   // driver: one valid assignment per edge, payload held while stalled
   always @(posedge clock) begin : driver
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(offered_req);
            offer = 1'b0;
            // flip between calm stretches and random gaps now and then
            if ($urandom_range(0, 11) == 0) sender_calm = !sender_calm;
            send_gap = sender_calm ? 0 : $urandom_range(0, 14);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_queue.size() != 0 &&
                         !(request_queue[0].hold_for_drain && pending_due.size() != 0)) begin
               offered_req = request_queue.pop_front();
               offer = 1'b1;
            end
         end
      end
      req_valid      <= offer;
      req_kind       <= offered_req.kind;
      req_task_index <= offered_req.task_index;
      req_now_ms     <= offered_req.now_ms;
      req_new_period <= offered_req.new_period;
   end

   // monitor: checks each response against the oldest expected due task
   always @(posedge clock) begin : monitor
      due_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_due.size() == 0) begin
               $error("unexpected response: due_task %0d last_due %0d",
                      rsp_due_task, rsp_last_due);
               mismatch_count++;
            end else begin
               want = pending_due.pop_front();
               if (rsp_due_task !== want.due_task) begin
                  $error("due_task: expected %0d, actual %0d", want.due_task, rsp_due_task);
                  mismatch_count++;
               end
               if (rsp_last_due !== want.last_due) begin
                  $error("last_due: expected %0d, actual %0d", want.last_due, rsp_last_due);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 11) == 0) receiver_calm = !receiver_calm;
            rsp_wait = receiver_calm ? 0 : $urandom_range(0, 14);
            // long hold-off while the sender keeps going, so the block backs up
            if (results_seen == HOLD_AT_RESULT) long_hold = LONG_HOLD;
         end else if (long_hold > 0) begin
            long_hold--;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (long_hold > 0) || (rsp_wait > 0);
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_LIMIT) begin
            $error("timeout: no transaction for %0d cycles, %0d responses outstanding",
                   STALL_LIMIT, pending_due.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] clock_ms;
      int          pick;
      logic [31:0] per;

      // default task table after reset
      for (int i = 0; i < TASKS; i++) begin
         sched_enabled[i]  = reset_enable(TASK_IDX_W'(i));
         sched_period[i]   = reset_period(TASK_IDX_W'(i));
         sched_last_run[i] = '0;
      end

      // directed: default table first, nothing due at zero age
      add_item(KIND_TICK, 0, 32'd0, 32'd0, 1'b0);
      add_item(KIND_TICK, 15, 32'd10, 32'hFFFF_FFFF, 1'b0);
      add_item(KIND_TICK, 0, 32'd50, 32'd0, 1'b0);
      for (int i = 2; i < TASKS; i++) add_item(KIND_ENABLE, i, 32'd0, 32'd0, 1'b0);
      // out-of-range indexes on every control kind
      add_item(KIND_ENABLE, 15, 32'd0, 32'd0, 1'b0);
      add_item(KIND_DISABLE, 9, 32'd0, 32'd0, 1'b0);
      add_item(KIND_SET_PERIOD, 12, 32'd0, 32'd1, 1'b0);
      // zero period clamps to one, widest period only matches widest age
      add_item(KIND_SET_PERIOD, 3, 32'd0, 32'd0, 1'b0);
      add_item(KIND_SET_PERIOD, 4, 32'd0, 32'hFFFF_FFFF, 1'b0);
      add_item(KIND_SET_PERIOD, 5, 32'd0, 32'd1, 1'b0);
      // time wrap-around
      add_item(KIND_TICK, 0, 32'hFFFF_FFFF, 32'd0, 1'b0);
      add_item(KIND_TICK, 0, 32'd3, 32'd0, 1'b0);
      // every task due in one tick
      add_item(KIND_SET_PERIOD, 0, 32'd0, 32'd1, 1'b0);
      add_item(KIND_SET_PERIOD, 1, 32'd0, 32'd1, 1'b0);
      add_item(KIND_SET_PERIOD, 2, 32'd0, 32'd1, 1'b0);
      add_item(KIND_SET_PERIOD, 4, 32'd0, 32'd1, 1'b0);
      add_item(KIND_TICK, 0, 32'd100, 32'd0, 1'b0);
      add_item(KIND_DISABLE, 0, 32'd0, 32'd0, 1'b0);
      add_item(KIND_TICK, 0, 32'd101, 32'd0, 1'b1);

      // random: mostly ticks walking forward in time, table edits in between
      clock_ms = 32'd101;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 30);
            add_item(KIND_TICK, $urandom_range(0, 15), clock_ms, $urandom, n == 120);
         end else if (pick < 70) begin
            case ($urandom_range(0, 6))
               0:       per = 32'd0;
               1:       per = $urandom;
               default: per = $urandom_range(1, 60);
            endcase
            add_item(KIND_SET_PERIOD, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(0, 5),
                     $urandom, per, 1'b0);
         end else if (pick < 87) begin
            add_item(KIND_ENABLE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(0, 5),
                     $urandom, $urandom, 1'b0);
         end else begin
            add_item(KIND_DISABLE, $urandom_range(0, 15), $urandom, $urandom, 1'b0);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // all requests out, then all responses in, then a short quiet tail
      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_due.size() != 0) @(posedge clock);
      repeat (TASKS + 20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ptd_pkg.sv
rtl/core/ptd_table.sv
rtl/core/ptd_ctrl.sv
rtl/core/periodic_task_dispatcher.sv
bench/periodic_task_dispatcher_test.sv
